// ===== rtl/rms_level_meter_macros.svh =====
// assertion macros for the rms level meter
`ifndef RMS_LEVEL_METER_MACROS_SVH
`define RMS_LEVEL_METER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define RLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rlm_pkg.sv =====
// shared widths and constants of the rms level meter
`default_nettype none

package rlm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W    = 38;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned LEVEL_W  = 15;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned VOLUME_W = 17;
  localparam int unsigned SMOOTH_W = 32;

  // iterative divider: quotient as wide as the sum, divisor as wide as full scale
  localparam int unsigned DIV_NW   = SUM_W;
  localparam int unsigned DIV_DW   = LEVEL_W;
  localparam int unsigned DIV_CW   = $clog2(DIV_NW);

  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]    COUNT_MAX  = {CNT_W{1'b1}};
  localparam logic [LEVEL_W-1:0]  RMS_MAX    = LEVEL_W'(16384);
  localparam logic [DIV_NW-1:0]   VOLUME_ONE = DIV_NW'(65536);

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_WEIGHT     = 1'b0,
    REG_FULL_SCALE = 1'b1
  } reg_idx_e;

endpackage

`default_nettype wire

// ===== rtl/rlm_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module rlm_div (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  input  wire  [rlm_pkg::DIV_NW-1:0]     dividend_i,
  input  wire  [rlm_pkg::DIV_DW-1:0]     divisor_i,
  output logic                           done_o,
  output logic [rlm_pkg::DIV_NW-1:0]     quotient_o
);
  import rlm_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DIV_CW-1:0]   cnt_q, cnt_d;
  logic [DIV_NW-1:0]   quo_q, quo_d;
  logic [DIV_DW-1:0]   rem_q, rem_d;
  logic [DIV_DW-1:0]   den_q, den_d;
  logic [DIV_DW:0]     shifted;
  logic                fits;

  assign shifted = {rem_q, quo_q[DIV_NW-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CW'(DIV_NW - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? DIV_DW'(shifted - {1'b0, den_q}) : shifted[DIV_DW-1:0];
      quo_d = {quo_q[DIV_NW-2:0], fits};
      cnt_d = cnt_q - DIV_CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/rms_level_meter.sv =====
// rms level meter top level: sequencer, shared multiplier, root and registers
//
//  channel  dir  handshake                  payload
//  in       in   in_valid_i / in_stall_o    left_sample_i, right_sample_i, last_of_buffer_i
//  out      out  out_valid_o / out_stall_i  rms_level_o, smoothed_level_o, scaled_volume_o
//  cfg      in   apb psel/penable/pready    paddr, pwdata, prdata
//
// a word that does not end a buffer passes through accept, two squares on the shared
// multiplier and accumulate. a word that ends a buffer goes on through the divider for
// the mean, the root steps, the smoothing states, the divider for the volume and the
// output load. in_stall_o is high from accept until the word is accumulated or, for a
// buffer end, until the result is in the output register; the output register holds
// while out_stall_i is high. reset clears accumulator, count, smoothed level
`default_nettype none
`include "rms_level_meter_macros.svh"

module rms_level_meter (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  signed [rlm_pkg::SAMPLE_W-1:0] left_sample_i,
  input  wire  signed [rlm_pkg::SAMPLE_W-1:0] right_sample_i,
  input  wire                                last_of_buffer_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [rlm_pkg::LEVEL_W-1:0]        rms_level_o,
  output logic [rlm_pkg::LEVEL_W-1:0]        smoothed_level_o,
  output logic [rlm_pkg::VOLUME_W-1:0]       scaled_volume_o,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [rlm_pkg::ADDR_W-1:0]         paddr,
  input  wire  [rlm_pkg::DATA_W-1:0]         pwdata,
  output logic [rlm_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import rlm_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_SQ_L     = 11'b000_0000_0010,
    ST_SQ_R     = 11'b000_0000_0100,
    ST_ACC_R    = 11'b000_0000_1000,
    ST_DIV_MEAN = 11'b000_0001_0000,
    ST_SQRT     = 11'b000_0010_0000,
    ST_MUL_OLD  = 11'b000_0100_0000,
    ST_MUL_NEW  = 11'b000_1000_0000,
    ST_SMOOTH   = 11'b001_0000_0000,
    ST_DIV_VOL  = 11'b010_0000_0000,
    ST_DONE     = 11'b100_0000_0000
  } state_e;

  localparam int unsigned MUL_AW = SMOOTH_W;
  localparam int unsigned MUL_BW = WEIGHT_W + 1;
  localparam int unsigned PROD_W = MUL_AW + MUL_BW;
  localparam int unsigned ACC_W  = PROD_W + 1;
  localparam logic [SUM_W-1:0] ROOT_BIT0 = SUM_W'(1) << (SUM_W - 2);

  function automatic logic [SAMPLE_W:0] magnitude(input logic [SAMPLE_W-1:0] v);
    logic [SAMPLE_W:0] ext;
    ext = {v[SAMPLE_W-1], v};
    return v[SAMPLE_W-1] ? (~ext + (SAMPLE_W+1)'(1)) : ext;
  endfunction

  state_e                 state_q, state_d;
  logic [SAMPLE_W-1:0]    left_q, right_q;
  logic                   last_q;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [SMOOTH_W-1:0]    sv_q, sv_d;
  logic [WEIGHT_W-1:0]    weight_q;
  logic [LEVEL_W-1:0]     fs_q;
  logic [PROD_W-1:0]      prod_q;
  logic [ACC_W-1:0]       acc_q;
  logic [SUM_W-1:0]       n_q, root_q, bit_q;
  logic [LEVEL_W-1:0]     rms_q;
  logic [VOLUME_W-1:0]    vol_q;
  logic                   out_valid_q;
  logic [LEVEL_W-1:0]     rms_out_q, smooth_out_q;
  logic [VOLUME_W-1:0]    vol_out_q;

  logic [MUL_AW-1:0]      mul_a;
  logic [MUL_BW-1:0]      mul_b;
  logic [SUM_W:0]         sum_add;
  logic [SUM_W-1:0]       sum_sat;
  logic [CNT_W:0]         cnt_add;
  logic [CNT_W-1:0]       cnt_sat;
  logic [ACC_W-1:0]       smooth_sum;
  logic [SUM_W:0]         trial;
  logic                   root_fits;
  logic [SUM_W-1:0]       root_next;
  logic                   out_load;
  logic                   cfg_wr;
  logic [DIV_NW-1:0]      div_dividend, div_quo;
  logic [DIV_DW-1:0]      div_divisor, fs_eff;
  logic                   div_start;
  logic                   div_done;
  logic                   div_state;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ_L: begin
        mul_a = MUL_AW'(magnitude(left_q));
        mul_b = MUL_BW'(magnitude(left_q));
      end
      ST_SQ_R: begin
        mul_a = MUL_AW'(magnitude(right_q));
        mul_b = MUL_BW'(magnitude(right_q));
      end
      ST_MUL_OLD: begin
        mul_a = sv_q;
        mul_b = MUL_BW'(65536) - {1'b0, weight_q};
      end
      ST_MUL_NEW: begin
        mul_a = MUL_AW'(rms_q);
        mul_b = {1'b0, weight_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(prod_q[2*SAMPLE_W-1:2]);
  assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
  assign cnt_add = {1'b0, cnt_q} + (CNT_W+1)'(2);
  assign cnt_sat = cnt_add[CNT_W] ? COUNT_MAX : cnt_add[CNT_W-1:0];

  assign smooth_sum = acc_q + {prod_q[ACC_W-WEIGHT_W-1:0], {WEIGHT_W{1'b0}}};

  assign trial     = {1'b0, root_q} + {1'b0, bit_q};
  assign root_fits = {1'b0, n_q} >= trial;
  assign root_next = root_fits ? ((root_q >> 1) + bit_q) : (root_q >> 1);

  assign fs_eff       = (fs_q == '0) ? DIV_DW'(1) : fs_q;
  assign div_start    = ((state_q == ST_ACC_R) && last_q) || (state_q == ST_SMOOTH);
  assign div_dividend = (state_q == ST_ACC_R) ? sum_sat : DIV_NW'(sv_d);
  assign div_divisor  = (state_q == ST_ACC_R) ? DIV_DW'(cnt_sat) : fs_eff;
  assign div_state    = (state_q == ST_DIV_MEAN) || (state_q == ST_DIV_VOL);

  rlm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    sv_d    = sv_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_SQ_L;
      ST_SQ_L:     state_d = ST_SQ_R;
      ST_SQ_R: begin
        sum_d   = sum_sat;
        state_d = ST_ACC_R;
      end
      ST_ACC_R: begin
        sum_d   = sum_sat;
        cnt_d   = cnt_sat;
        state_d = last_q ? ST_DIV_MEAN : ST_IDLE;
      end
      ST_DIV_MEAN: if (div_done) state_d = ST_SQRT;
      ST_SQRT:     if (bit_q[0]) state_d = ST_MUL_OLD;
      ST_MUL_OLD:  state_d = ST_MUL_NEW;
      ST_MUL_NEW:  state_d = ST_SMOOTH;
      ST_SMOOTH: begin
        sv_d    = smooth_sum[SMOOTH_W+WEIGHT_W-1:WEIGHT_W];
        state_d = ST_DIV_VOL;
      end
      ST_DIV_VOL:  if (div_done) state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          sum_d   = '0;
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      sv_q        <= '0;
      weight_q    <= WEIGHT_W'(4588);
      fs_q        <= LEVEL_W'(5571);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      sv_q    <= sv_d;
      if (cfg_wr) begin
        unique case (reg_idx_e'(paddr[2]))
          REG_WEIGHT:     weight_q <= pwdata[WEIGHT_W-1:0];
          REG_FULL_SCALE: fs_q     <= pwdata[LEVEL_W-1:0];
          default:        ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == ST_IDLE && in_valid_i) begin
      left_q  <= left_sample_i;
      right_q <= right_sample_i;
      last_q  <= last_of_buffer_i;
    end
    if (state_q == ST_MUL_NEW) begin
      acc_q <= ACC_W'(prod_q) + ACC_W'(32768);
    end
    if (state_q == ST_DIV_MEAN && div_done) begin
      n_q    <= div_quo;
      root_q <= '0;
      bit_q  <= ROOT_BIT0;
    end else if (state_q == ST_SQRT) begin
      if (root_fits) begin
        n_q <= n_q - trial[SUM_W-1:0];
      end
      root_q <= root_next;
      bit_q  <= bit_q >> 2;
      if (bit_q[0]) begin
        rms_q <= (root_next > SUM_W'(RMS_MAX)) ? RMS_MAX : root_next[LEVEL_W-1:0];
      end
    end
    if (state_q == ST_DIV_VOL && div_done) begin
      vol_q <= (div_quo > VOLUME_ONE) ? VOLUME_ONE[VOLUME_W-1:0] : div_quo[VOLUME_W-1:0];
    end
    if (out_load) begin
      rms_out_q    <= rms_q;
      smooth_out_q <= sv_q[LEVEL_W+WEIGHT_W-1:WEIGHT_W];
      vol_out_q    <= vol_q;
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_WEIGHT:     prdata = DATA_W'(weight_q);
      REG_FULL_SCALE: prdata = DATA_W'(fs_q);
      default:        prdata = '0;
    endcase
  end

  assign pready           = 1'b1;
  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign rms_level_o      = rms_out_q;
  assign smoothed_level_o = smooth_out_q;
  assign scaled_volume_o  = vol_out_q;

  `RLM_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input not stalled")
  `RLM_ASSERT_IMP(a_div_done_state, div_done, div_state, "divider done outside a divide state")
  `RLM_ASSERT_IMP(a_out_from_done, $rose(out_valid_o), $past(state_q == ST_DONE), "early output")
  `RLM_ASSERT_IMP(a_count_even, cnt_q[0], cnt_q == COUNT_MAX, "odd sample count")

endmodule

`default_nettype wire
